>>> sv/rtsfpe_pkg.sv
// shared constants for the rolling-code frame pulse encoder
package rtsfpe_pkg;

    localparam int unsigned FRAME_W    = 56;
    localparam int unsigned BYTES      = FRAME_W / 8;
    localparam int unsigned IDX_W      = $clog2(FRAME_W);
    localparam int unsigned SYMBOL_W   = 12;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned ADDR_W     = 24;
    localparam int unsigned CMD_W      = 4;
    localparam int unsigned CODE_W     = 16;
    localparam int unsigned PADDR_W    = 4;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [7:0] KEY_BYTE    = 8'hA0;
    localparam logic [3:0] NIBBLE_MASK = 4'b1111;

    localparam logic [DUR_W-1:0] WAKE_MARK_US   = 16'd9415;
    localparam logic [DUR_W-1:0] WAKE_SPACE_US  = 16'd9656;
    localparam logic [DUR_W-1:0] SWSYNC_MARK_US = 16'd4550;
    localparam logic [DUR_W-1:0] GAP_US         = 16'd415;

    localparam logic [SYMBOL_W-1:0] SYMBOL_RESET       = 12'd640;
    localparam logic [COUNT_W-1:0]  REPEAT_RESET       = 4'd5;
    localparam logic [COUNT_W-1:0]  FIRST_SYNC_RESET   = 4'd2;
    localparam logic [COUNT_W-1:0]  REPEAT_SYNC_RESET  = 4'd7;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    localparam logic [1:0] REG_SYMBOL      = 2'd0;
    localparam logic [1:0] REG_REPEAT      = 2'd1;
    localparam logic [1:0] REG_FIRST_SYNC  = 2'd2;
    localparam logic [1:0] REG_REPEAT_SYNC = 2'd3;

endpackage

>>> sv/rtsfpe_frame_build.sv
// frame builder: key byte, checksum nibble and xor chaining of the 7 bytes
module rtsfpe_frame_build (
    input  logic [rtsfpe_pkg::ADDR_W-1:0]  address,
    input  logic [rtsfpe_pkg::CMD_W-1:0]   command,
    input  logic [rtsfpe_pkg::CODE_W-1:0]  rolling_code,
    output logic [rtsfpe_pkg::FRAME_W-1:0] frame
);

    logic [7:0] raw     [rtsfpe_pkg::BYTES];
    logic [7:0] chained [rtsfpe_pkg::BYTES];
    logic [3:0] sum;

    always_comb
    begin
        raw[0] = rtsfpe_pkg::KEY_BYTE | {4'b0000, rolling_code[3:0]};
        raw[1] = {command, 4'b0000};
        raw[2] = rolling_code[15:8];
        raw[3] = rolling_code[7:0];
        raw[4] = address[23:16];
        raw[5] = address[15:8];
        raw[6] = address[7:0];
        sum = '0;
        for (int i = 0; i < rtsfpe_pkg::BYTES; i++)
        begin
            sum = sum ^ raw[i][7:4] ^ raw[i][3:0];
        end
        chained[0] = raw[0];
        chained[1] = (raw[1] | {4'b0000, sum & rtsfpe_pkg::NIBBLE_MASK}) ^ chained[0];
        for (int i = 2; i < rtsfpe_pkg::BYTES; i++)
        begin
            chained[i] = raw[i] ^ chained[i-1];
        end
        for (int i = 0; i < rtsfpe_pkg::BYTES; i++)
        begin
            frame[rtsfpe_pkg::FRAME_W-1-8*i -: 8] = chained[i];
        end
    end

endmodule

>>> sv/rts_frame_pulse_encoder.sv
// top level: register port, pulse sequencer and result register
// A start word (op 0) builds and latches the 56-bit frame and returns a result with
// valid_res low; every next word (op 1) returns one mark or space pulse of the
// transmission: wake-up pair, sync pairs, software sync, 56 Manchester bits MSB first
// and the gap, repeated from the sync pairs on for repeat_reg more frames; last marks
// the final gap. One word is taken per cycle; the result register frees in the cycle it
// is taken, so in_ready stays high while the consumer keeps out_ready high.
module rts_frame_pulse_encoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rtsfpe_pkg::PADDR_W-1:0]     paddr,
    input  logic [rtsfpe_pkg::PDATA_W-1:0]     pwdata,
    output logic [rtsfpe_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [rtsfpe_pkg::ADDR_W-1:0]      address,
    input  logic [rtsfpe_pkg::CMD_W-1:0]       command,
    input  logic [rtsfpe_pkg::CODE_W-1:0]      rolling_code,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               valid_res,
    output logic                               level,
    output logic [rtsfpe_pkg::DUR_W-1:0]       duration_us,
    output logic                               last
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAKE,
        PH_SYNC,
        PH_SWSYNC,
        PH_DATA,
        PH_GAP
    } phase_t;

    logic [rtsfpe_pkg::SYMBOL_W-1:0] symbol_reg;
    logic [rtsfpe_pkg::COUNT_W-1:0]  repeat_reg;
    logic [rtsfpe_pkg::COUNT_W-1:0]  first_sync_reg;
    logic [rtsfpe_pkg::COUNT_W-1:0]  repeat_sync_reg;
    logic                            cfg_write;

    phase_t                          phase_reg, phase_next, phase_eff;
    logic [rtsfpe_pkg::FRAME_W-1:0]  frame_reg, frame_next, frame_built;
    logic [rtsfpe_pkg::COUNT_W-1:0]  sync_left_reg, sync_left_next;
    logic [rtsfpe_pkg::IDX_W-1:0]    bit_index_reg, bit_index_next, bit_sel, bit_inc;
    logic                            second_half_reg, second_half_next;
    logic [rtsfpe_pkg::COUNT_W-1:0]  frames_left_reg, frames_left_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            valid_res_reg, valid_res_next;
    logic                            level_reg, level_next;
    logic [rtsfpe_pkg::DUR_W-1:0]    dur_reg, dur_next;
    logic                            last_reg, last_next;

    logic                            accept;
    logic                            data_bit;
    logic [rtsfpe_pkg::DUR_W-1:0]    symbol_dur, sync_dur;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_reg      <= rtsfpe_pkg::SYMBOL_RESET;
            repeat_reg      <= rtsfpe_pkg::REPEAT_RESET;
            first_sync_reg  <= rtsfpe_pkg::FIRST_SYNC_RESET;
            repeat_sync_reg <= rtsfpe_pkg::REPEAT_SYNC_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                rtsfpe_pkg::REG_SYMBOL:      symbol_reg      <= pwdata[rtsfpe_pkg::SYMBOL_W-1:0];
                rtsfpe_pkg::REG_REPEAT:      repeat_reg      <= pwdata[rtsfpe_pkg::COUNT_W-1:0];
                rtsfpe_pkg::REG_FIRST_SYNC:  first_sync_reg  <= pwdata[rtsfpe_pkg::COUNT_W-1:0];
                rtsfpe_pkg::REG_REPEAT_SYNC: repeat_sync_reg <= pwdata[rtsfpe_pkg::COUNT_W-1:0];
                default:                     symbol_reg      <= symbol_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rtsfpe_pkg::REG_SYMBOL:      prdata = 32'(symbol_reg);
            rtsfpe_pkg::REG_REPEAT:      prdata = 32'(repeat_reg);
            rtsfpe_pkg::REG_FIRST_SYNC:  prdata = 32'(first_sync_reg);
            rtsfpe_pkg::REG_REPEAT_SYNC: prdata = 32'(repeat_sync_reg);
            default:                     prdata = '0;
        endcase
    end

    rtsfpe_frame_build u_frame_build (
        .address      (address),
        .command      (command),
        .rolling_code (rolling_code),
        .frame        (frame_built)
    );

    // handshake
    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign valid_res   = valid_res_reg;
    assign level       = level_reg;
    assign duration_us = dur_reg;
    assign last        = last_reg;

    assign symbol_dur = {4'b0000, symbol_reg};
    assign sync_dur   = {2'b00, symbol_reg, 2'b00};
    assign bit_sel    = rtsfpe_pkg::IDX_W'(rtsfpe_pkg::FRAME_W - 1) - bit_index_reg;
    assign data_bit   = frame_reg[bit_sel];
    assign bit_inc    = bit_index_reg + 1'b1;

    always_comb
    begin
        phase_next       = phase_reg;
        frame_next       = frame_reg;
        sync_left_next   = sync_left_reg;
        bit_index_next   = bit_index_reg;
        second_half_next = second_half_reg;
        frames_left_next = frames_left_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        valid_res_next   = valid_res_reg;
        level_next       = level_reg;
        dur_next         = dur_reg;
        last_next        = last_reg;
        phase_eff        = phase_reg;
        if (phase_reg == PH_SYNC && sync_left_reg == '0)
        begin
            phase_eff = PH_SWSYNC;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            valid_res_next = 1'b0;
            level_next     = 1'b0;
            dur_next       = '0;
            last_next      = 1'b0;
            if (op == rtsfpe_pkg::OP_START)
            begin
                frame_next       = frame_built;
                phase_next       = PH_WAKE;
                second_half_next = 1'b0;
                sync_left_next   = first_sync_reg;
                bit_index_next   = '0;
                frames_left_next = repeat_reg;
            end
            else
            begin
                phase_next     = phase_eff;
                valid_res_next = (phase_eff != PH_IDLE);
                unique case (phase_eff)
                    PH_WAKE:
                    begin
                        if (!second_half_reg)
                        begin
                            level_next       = 1'b1;
                            dur_next         = rtsfpe_pkg::WAKE_MARK_US;
                            second_half_next = 1'b1;
                        end
                        else
                        begin
                            dur_next         = rtsfpe_pkg::WAKE_SPACE_US;
                            second_half_next = 1'b0;
                            phase_next       = PH_SYNC;
                        end
                    end
                    PH_SYNC:
                    begin
                        dur_next = sync_dur;
                        if (!second_half_reg)
                        begin
                            level_next       = 1'b1;
                            second_half_next = 1'b1;
                        end
                        else
                        begin
                            second_half_next = 1'b0;
                            sync_left_next   = sync_left_reg - 1'b1;
                        end
                    end
                    PH_SWSYNC:
                    begin
                        if (!second_half_reg)
                        begin
                            level_next       = 1'b1;
                            dur_next         = rtsfpe_pkg::SWSYNC_MARK_US;
                            second_half_next = 1'b1;
                        end
                        else
                        begin
                            dur_next         = symbol_dur;
                            second_half_next = 1'b0;
                            phase_next       = PH_DATA;
                            bit_index_next   = '0;
                        end
                    end
                    PH_DATA:
                    begin
                        dur_next = symbol_dur;
                        if (!second_half_reg)
                        begin
                            level_next       = !data_bit;
                            second_half_next = 1'b1;
                        end
                        else
                        begin
                            level_next       = data_bit;
                            second_half_next = 1'b0;
                            bit_index_next   = bit_inc;
                            if (bit_inc >= rtsfpe_pkg::IDX_W'(rtsfpe_pkg::FRAME_W))
                            begin
                                phase_next = PH_GAP;
                            end
                        end
                    end
                    PH_GAP:
                    begin
                        dur_next         = rtsfpe_pkg::GAP_US;
                        second_half_next = 1'b0;
                        if (frames_left_reg == '0)
                        begin
                            last_next  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            frames_left_next = frames_left_reg - 1'b1;
                            sync_left_next   = repeat_sync_reg;
                            bit_index_next   = '0;
                            phase_next       = PH_SYNC;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            frame_reg       <= '0;
            sync_left_reg   <= '0;
            bit_index_reg   <= '0;
            second_half_reg <= 1'b0;
            frames_left_reg <= '0;
            out_valid_reg   <= 1'b0;
            valid_res_reg   <= 1'b0;
            level_reg       <= 1'b0;
            dur_reg         <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            frame_reg       <= frame_next;
            sync_left_reg   <= sync_left_next;
            bit_index_reg   <= bit_index_next;
            second_half_reg <= second_half_next;
            frames_left_reg <= frames_left_next;
            out_valid_reg   <= out_valid_next;
            valid_res_reg   <= valid_res_next;
            level_reg       <= level_next;
            dur_reg         <= dur_next;
            last_reg        <= last_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_is_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> valid_res && !level && duration_us == rtsfpe_pkg::GAP_US)
        else $error("last word is not a valid gap pulse");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == rtsfpe_pkg::OP_START |=> phase_reg == PH_WAKE && !valid_res_reg
            && !second_half_reg && bit_index_reg == '0)
        else $error("start word did not restart the sequence");

    a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= rtsfpe_pkg::IDX_W'(rtsfpe_pkg::FRAME_W))
        else $error("bit index past end of frame");

    a_idle_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == rtsfpe_pkg::OP_NEXT && phase_reg == PH_IDLE |=> !valid_res_reg
            && phase_reg == PH_IDLE)
        else $error("pulse given while idle");
`endif

endmodule
